/* rtl/core/pou_pkg.sv */
// Shared types, constants and the sine table builder for the pose update block.
// Used by the channel interfaces and all modules under rtl/core.
package pou_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int HEADING_BITS_DEF    = 16;

    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    typedef struct packed {
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic        [15:0] pose_heading;
        logic signed [15:0] odometry_dx;
        logic signed [15:0] odometry_dy;
        logic signed [15:0] odometry_dheading;
    } t_pose_in;

    typedef struct packed {
        logic signed [23:0] new_x;
        logic signed [23:0] new_y;
        logic        [15:0] new_heading;
        logic               saturated;
    } t_pose_out;

    // round(32767*sin(2*pi*i/2^tb)), halves away from zero, built from the
    // first quadrant by symmetry. Evaluated at elaboration only.
    function automatic logic signed [15:0] sine_entry(input int tb, input int i);
        int  quarter;
        int  q;
        int  r;
        int  k;
        int  mag;
        real step;
        real v;
        quarter = 1 << (tb - 2);
        q       = (i >> (tb - 2)) & 3;
        r       = i & (quarter - 1);
        k       = ((q & 1) != 0) ? quarter - r : r;
        step    = 1.5707963267948966;
        for (int n = 0; n < tb - 2; n++) begin
            step = step * 0.5;
        end
        if (k >= quarter) begin
            mag = 32767;
        end else begin
            v   = 32767.0 * $sin(step * k);
            mag = $rtoi(v + 0.5);
        end
        if ((q & 2) != 0) begin
            mag = -mag;
        end
        return 16'(mag);
    endfunction

endpackage

/* rtl/core/pou_if.sv */
// Valid/ready channel interfaces for pose update input and result items.
// Depends on pou_pkg for the payload types.
interface pou_in_if;
    import pou_pkg::*;
    logic     valid;
    logic     ready;
    t_pose_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pou_out_if;
    import pou_pkg::*;
    logic      valid;
    logic      ready;
    t_pose_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/pou_sine_rom.sv */
// Full-circle Q1.15 sine ROM with registered sine and cosine reads.
// Depends on pou_pkg for the table builder.
module pou_sine_rom #(
    parameter int TABLE_BITS = pou_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [TABLE_BITS-1:0]   i_idx,
    output logic signed [15:0]      o_sin,
    output logic signed [15:0]      o_cos
);
    import pou_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam logic [TABLE_BITS-1:0] QUARTER = TABLE_BITS'(TABLE_SIZE / 4);

    typedef logic signed [15:0] t_rom [TABLE_SIZE];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = sine_entry(TABLE_BITS, i);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic signed [15:0]    r_sin;
    logic signed [15:0]    r_cos;
    logic [TABLE_BITS-1:0] cos_idx;

    // cosine is a quarter turn further on, wrapping around the circle
    assign cos_idx = i_idx + QUARTER;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= SINE_ROM[i_idx];
            r_cos <= SINE_ROM[cos_idx];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

/* rtl/core/pou_rotate.sv */
// Rotation of the odometry offset: registered products, then rounded sums,
// position add and saturation. Depends on pou_pkg for range limits.
module pou_rotate (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_sin,
    input  logic signed [15:0] i_cos,
    input  logic signed [15:0] i_dx,
    input  logic signed [15:0] i_dy,
    input  logic signed [23:0] i_x,
    input  logic signed [23:0] i_y,
    output logic signed [23:0] o_x,
    output logic signed [23:0] o_y,
    output logic               o_sat
);
    import pou_pkg::*;

    logic signed [31:0] r_cdx;
    logic signed [31:0] r_sdy;
    logic signed [31:0] r_sdx;
    logic signed [31:0] r_cdy;
    logic signed [23:0] r_x;
    logic signed [23:0] r_y;

    logic signed [32:0] sum_x;
    logic signed [32:0] sum_y;
    logic signed [17:0] rot_x;
    logic signed [17:0] rot_y;
    logic signed [24:0] pos_x;
    logic signed [24:0] pos_y;
    logic               sat_x;
    logic               sat_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cdx <= i_cos * i_dx;
            r_sdy <= i_sin * i_dy;
            r_sdx <= i_sin * i_dx;
            r_cdy <= i_cos * i_dy;
            r_x   <= i_x;
            r_y   <= i_y;
        end
    end

    always_comb begin
        sum_x = 33'(r_cdx) - 33'(r_sdy);
        sum_y = 33'(r_sdx) + 33'(r_cdy);
        // round half up: add 2^14, floor shift by 15
        rot_x = 18'((sum_x + 33'sd16384) >>> 15);
        rot_y = 18'((sum_y + 33'sd16384) >>> 15);
        pos_x = 25'(r_x) + 25'(rot_x);
        pos_y = 25'(r_y) + 25'(rot_y);
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (pos_x > 25'(POS_MAX)) begin
            o_x = POS_MAX;
        end else if (pos_x < 25'(POS_MIN)) begin
            o_x = POS_MIN;
        end else begin
            o_x   = 24'(pos_x);
            sat_x = 1'b0;
        end
        if (pos_y > 25'(POS_MAX)) begin
            o_y = POS_MAX;
        end else if (pos_y < 25'(POS_MIN)) begin
            o_y = POS_MIN;
        end else begin
            o_y   = 24'(pos_y);
            sat_y = 1'b0;
        end
        o_sat = sat_x | sat_y;
    end

endmodule

/* rtl/core/pose_odometry_update.sv */
// Top level of the 2D odometry pose update: pipeline control and heading path.
// Depends on pou_pkg, pou_if, pou_sine_rom and pou_rotate.
//
// Usage:
//   i_pose carries one pose plus a robot-frame odometry offset per transfer;
//   o_pose returns exactly one updated pose per input, in order.
//   Both channels transfer when valid and ready are high at a rising edge.
// Path: the item passes four registers (input register, sine ROM read,
//   product register, output register), the first loaded at the transfer
//   edge; o_pose.valid rises when the output register is loaded.
// Throughput: one item per cycle while o_pose.ready is high; each stage holds
//   one item and moves on as soon as the stage after it is empty or moving.
// Stall: when o_pose.ready is low the result holds in the output register;
//   upstream stages keep filling until all four are full, then
//   i_pose.ready drops.
// Reset: i_rst_n low at a clock edge empties all stages; nothing else
//   needs clearing, and items are accepted from the first cycle after.
module pose_odometry_update #(
    parameter int SINE_TABLE_BITS = pou_pkg::SINE_TABLE_BITS_DEF,
    parameter int HEADING_BITS    = pou_pkg::HEADING_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pou_in_if.sink   i_pose,
    pou_out_if.source o_pose
);
    import pou_pkg::*;

    localparam int TB  = SINE_TABLE_BITS;
    localparam int HB  = HEADING_BITS;
    localparam int SHR = (HB >= TB) ? HB - TB : 0;
    localparam int SHL = (HB >= TB) ? 0 : TB - HB;

    // stage valids
    logic r_v0, r_v1, r_v2, r_v3;
    logic n_v0, n_v1, n_v2, n_v3;
    logic en0, en1, en2, en3;

    t_pose_in           r_in;
    logic signed [23:0] r1_x;
    logic signed [23:0] r1_y;
    logic signed [15:0] r1_dx;
    logic signed [15:0] r1_dy;
    logic        [15:0] r1_nh;
    logic        [15:0] r2_nh;
    t_pose_out          r_out;

    logic [HB-1:0]        head;
    logic signed [HB-1:0] dhead;
    logic [HB-1:0]        sum_head;
    logic [TB-1:0]        tbl_idx;
    logic signed [15:0]   sin_q;
    logic signed [15:0]   cos_q;
    logic signed [23:0]   rot_x;
    logic signed [23:0]   rot_y;
    logic                 rot_sat;

    assign en3 = !r_v3 || o_pose.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign i_pose.ready = en0;
    assign o_pose.valid = r_v3;
    assign o_pose.data  = r_out;

    always_comb begin
        n_v0 = en0 ? i_pose.valid : r_v0;
        n_v1 = en1 ? r_v0 : r_v1;
        n_v2 = en2 ? r_v1 : r_v2;
        n_v3 = en3 ? r_v2 : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // heading path and table index, taken from the input register
    always_comb begin
        head     = HB'(r_in.pose_heading);
        dhead    = HB'(r_in.odometry_dheading);
        sum_head = head + dhead;
        tbl_idx  = TB'(head >> SHR) << SHL;
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_in <= i_pose.data;
        end
        if (en1) begin
            r1_x  <= r_in.pose_x;
            r1_y  <= r_in.pose_y;
            r1_dx <= r_in.odometry_dx;
            r1_dy <= r_in.odometry_dy;
            r1_nh <= 16'(sum_head);
        end
        if (en2) begin
            r2_nh <= r1_nh;
        end
        if (en3) begin
            r_out.new_x       <= rot_x;
            r_out.new_y       <= rot_y;
            r_out.new_heading <= r2_nh;
            r_out.saturated   <= rot_sat;
        end
    end

    pou_sine_rom #(
        .TABLE_BITS (TB)
    ) u_sine_rom (
        .i_clk (i_clk),
        .i_en  (en1),
        .i_idx (tbl_idx),
        .o_sin (sin_q),
        .o_cos (cos_q)
    );

    pou_rotate u_rotate (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_sin (sin_q),
        .i_cos (cos_q),
        .i_dx  (r1_dx),
        .i_dy  (r1_dy),
        .i_x   (r1_x),
        .i_y   (r1_y),
        .o_x   (rot_x),
        .o_y   (rot_y),
        .o_sat (rot_sat)
    );

    // an accepted transfer always lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pose.valid && i_pose.ready |=> r_v0)
        else $error("accepted input did not enter the pipeline");

    // input is only refused when the whole pipeline is blocked
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pose.ready |-> (r_v0 && r_v1 && r_v2 && r_v3 && !o_pose.ready))
        else $error("input refused while pipeline has room");

    // a clamped result sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pose.valid && o_pose.data.saturated |->
            (o_pose.data.new_x == POS_MAX || o_pose.data.new_x == POS_MIN ||
             o_pose.data.new_y == POS_MAX || o_pose.data.new_y == POS_MIN))
        else $error("saturated flag without a clamped position");

endmodule
